### hdl/marker_length_frame_deframer_macros.svh
// assertion macros for the marker / length frame deframer
// used by the top level; expects clk and rst in scope
`ifndef MARKER_LENGTH_FRAME_DEFRAMER_MACROS_SVH
`define MARKER_LENGTH_FRAME_DEFRAMER_MACROS_SVH

// same-cycle implication, quiet during reset
`define MLFD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define MLFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/mlfd_pkg.sv
// shared types, codes and helpers of the marker / length frame deframer
// no dependencies; imported by every module of the block
package mlfd_pkg;

  localparam int COUNT_BITS = 32;
  localparam int WIN_DEPTH  = 8;
  localparam int LEN_W      = 32;
  localparam int OUT_CNT_W  = 32;

  // input command codes
  typedef enum logic {
    CMD_BYTE  = 1'b0,
    CMD_FLUSH = 1'b1
  } cmd_t;

  // result kinds
  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_DISCARD = 2'd2
  } kind_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_MAX_LEN = 2'd0,
    REG_CTRL_MK = 2'd1,
    REG_VIDEO_MK = 2'd2,
    REG_AUDIO_MK = 2'd3
  } reg_idx_t;

  // outcome of one window evaluation
  typedef struct packed {
    logic             accept;
    logic             discard;
    logic             oversize;
    logic [2:0]       drops;
    logic [7:0]       lead_byte;
    logic [7:0]       channel;
    logic [LEN_W-1:0] plen;
  } hunt_res_t;

  // counter events of one transaction
  typedef struct packed {
    logic       upd;
    logic       frame;
    logic       oversize;
    logic [2:0] drops;
  } stat_evt_t;

  // saturating add of a small increment
  function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] cnt,
                                                    input logic [2:0] inc);
    logic [COUNT_BITS:0] sum;
    sum = {1'b0, cnt} + (COUNT_BITS + 1)'(inc);
    return sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
  endfunction

endpackage

### hdl/mlfd_hunt.sv
// header hunting window: appends a byte, tests marker positions, shifts out drops
// depends on mlfd_pkg
module mlfd_hunt
  import mlfd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic             flush,
  input  logic [7:0]       data_byte,
  input  logic [7:0]       control_marker,
  input  logic [7:0]       video_marker,
  input  logic [7:0]       audio_marker,
  input  logic [LEN_W-1:0] max_len,
  output hunt_res_t        res
);

  logic [7:0]       win [WIN_DEPTH];
  logic [3:0]       fill;
  logic [7:0]       app [WIN_DEPTH];
  logic [7:0]       win_next [WIN_DEPTH];
  logic [3:0]       fill_app;
  logic [5:0]       magic;
  logic             full;
  logic             over0;
  logic             accept;
  logic             found;
  logic [2:0]       drops;
  logic [3:0]       idx;
  logic [LEN_W-1:0] plen;

  // window with the new byte appended at the fill point
  always_comb begin
    for (int i = 0; i < WIN_DEPTH; i++) begin
      app[i] = (4'(i) == fill) ? data_byte : win[i];
    end
    fill_app = fill + 4'd1;
  end

  // four equal marker bytes at each start position
  always_comb begin
    magic = '0;
    for (int j = 0; j < 5; j++) begin
      magic[j] = (app[j] == app[j+1]) && (app[j] == app[j+2]) && (app[j] == app[j+3]) &&
                 ((app[j] == control_marker) || (app[j] == video_marker) ||
                  (app[j] == audio_marker));
    end
  end

  // length check on a full window
  assign plen   = {app[7], app[6], app[5], app[4]};
  assign full   = (fill_app == 4'(WIN_DEPTH));
  assign over0  = full && magic[0] && (plen > max_len);
  assign accept = full && magic[0] && !over0;

  // first position that stops the hunt; positions before it are dropped
  always_comb begin
    found = 1'b0;
    drops = '0;
    for (int j = 0; j < 6; j++) begin
      if (!found) begin
        if ((fill_app < 4'(j + 4)) || (magic[j] && !((j == 0) && over0))) begin
          found = 1'b1;
        end else begin
          drops = drops + 3'd1;
        end
      end
    end
  end

  // shifted window after the drops
  always_comb begin
    for (int i = 0; i < WIN_DEPTH; i++) begin
      idx = 4'(i) + {1'b0, drops};
      win_next[i] = (!accept && (idx < 4'(WIN_DEPTH))) ? app[idx[2:0]] : 8'd0;
    end
  end

  // window state
  always_ff @(posedge clk) begin
    if (rst || flush) begin
      for (int i = 0; i < WIN_DEPTH; i++) win[i] <= 8'd0;
      fill <= '0;
    end else if (step) begin
      for (int i = 0; i < WIN_DEPTH; i++) win[i] <= win_next[i];
      fill <= accept ? 4'd0 : (fill_app - {1'b0, drops});
    end
  end

  assign res.accept    = accept;
  assign res.discard   = (drops != 3'd0);
  assign res.oversize  = over0;
  assign res.drops     = drops;
  assign res.lead_byte = app[0];
  assign res.channel   = app[0];
  assign res.plen      = plen;

endmodule

### hdl/mlfd_stats.sv
// saturating frame, discard and oversize counters
// depends on mlfd_pkg
module mlfd_stats
  import mlfd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  stat_evt_t             evt,
  output logic [COUNT_BITS-1:0] frames_next,
  output logic [COUNT_BITS-1:0] discards_next,
  output logic [COUNT_BITS-1:0] oversize_next
);

  logic [COUNT_BITS-1:0] frames;
  logic [COUNT_BITS-1:0] discards;
  logic [COUNT_BITS-1:0] oversize;

  // counter values after this transaction
  always_comb begin
    frames_next   = frames;
    discards_next = discards;
    oversize_next = oversize;
    if (evt.upd) begin
      frames_next   = sat_add(frames, {2'b00, evt.frame});
      discards_next = sat_add(discards, evt.drops);
      oversize_next = sat_add(oversize, {2'b00, evt.oversize});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frames   <= '0;
      discards <= '0;
      oversize <= '0;
    end else begin
      frames   <= frames_next;
      discards <= discards_next;
      oversize <= oversize_next;
    end
  end

endmodule

### hdl/marker_length_frame_deframer.sv
// top level of the marker / length frame deframer: ports, frame state, result register
// depends on mlfd_pkg, mlfd_hunt, mlfd_stats and the assertion macro header
//
// One transaction enters per clock cycle unless the result register is held: each byte goes
// from the input register through one window compare and counter update into the result
// register. A header is four equal bytes matching a configured channel marker plus a
// little-endian 32-bit length within the limit; payload bytes then pass straight through
// tagged with the channel. A byte that produces no result (window still filling, flush)
// still passes through the input register. Throughput drops only while the result register
// is held by m_tready low. Nothing needs clearing after reset. Configuration is to be
// written by the user only while the block is idle; the block itself does not enforce it.
`include "marker_length_frame_deframer_macros.svh"

module marker_length_frame_deframer
  import mlfd_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  // configuration write port
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [31:0]   cfg_data,
  // input stream
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [7:0]    s_tdata,   // data_byte
  input  logic          s_tuser,   // cmd
  // result stream
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [143:0]  m_tdata,   // channel, frame_len, out_byte, frames_seen,
                                   // discards_seen, oversize_seen
  output logic [2:0]    m_tuser,   // kind[1:0], oversize
  output logic          m_tlast    // last
);

  // configuration registers
  logic [LEN_W-1:0] max_len;
  logic [7:0]       control_marker;
  logic [7:0]       video_marker;
  logic [7:0]       audio_marker;

  // input register
  logic       in_valid;
  cmd_t       in_cmd;
  logic [7:0] in_byte;
  logic       adv;

  // frame state
  logic             in_payload;
  logic [7:0]       frame_channel;
  logic [LEN_W-1:0] bytes_left;
  logic [LEN_W-1:0] frame_length;

  // processing
  logic                  is_flush;
  logic                  hunt_step;
  hunt_res_t             hres;
  stat_evt_t             evt;
  logic [COUNT_BITS-1:0] frames_next;
  logic [COUNT_BITS-1:0] discards_next;
  logic [COUNT_BITS-1:0] oversize_next;
  logic                  has_res;
  kind_t                 res_kind;
  logic [7:0]            res_channel;
  logic [LEN_W-1:0]      res_len;
  logic [7:0]            res_byte;
  logic                  res_last;
  logic                  res_over;

  // result register
  kind_t                out_kind;
  logic [7:0]           out_channel;
  logic [LEN_W-1:0]     out_len;
  logic [7:0]           out_byte;
  logic                 out_last;
  logic                 out_over;
  logic [OUT_CNT_W-1:0] out_frames;
  logic [OUT_CNT_W-1:0] out_discards;
  logic [OUT_CNT_W-1:0] out_oversize;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      max_len        <= 32'd1048576;
      control_marker <= 8'd0;
      video_marker   <= 8'd1;
      audio_marker   <= 8'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_LEN:  max_len        <= cfg_data;
        REG_CTRL_MK:  control_marker <= cfg_data[7:0];
        REG_VIDEO_MK: video_marker   <= cfg_data[7:0];
        REG_AUDIO_MK: audio_marker   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // handshake: the held transaction moves on when the result slot is free
  assign adv      = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_cmd  <= cmd_t'(s_tuser);
      in_byte <= s_tdata;
    end
  end

  assign is_flush  = (in_cmd == CMD_FLUSH);
  assign hunt_step = adv && !is_flush && !in_payload;

  mlfd_hunt u_hunt (
    .clk            (clk),
    .rst            (rst),
    .step           (hunt_step),
    .flush          (adv && is_flush),
    .data_byte      (in_byte),
    .control_marker (control_marker),
    .video_marker   (video_marker),
    .audio_marker   (audio_marker),
    .max_len        (max_len),
    .res            (hres)
  );

  // counter events
  always_comb begin
    evt.upd      = hunt_step;
    evt.frame    = hres.accept;
    evt.oversize = hres.oversize;
    evt.drops    = hres.drops;
  end

  mlfd_stats u_stats (
    .clk           (clk),
    .rst           (rst),
    .evt           (evt),
    .frames_next   (frames_next),
    .discards_next (discards_next),
    .oversize_next (oversize_next)
  );

  // result selection
  always_comb begin
    has_res     = 1'b0;
    res_kind    = KIND_DISCARD;
    res_channel = 8'd0;
    res_len     = '0;
    res_byte    = 8'd0;
    res_last    = 1'b0;
    res_over    = 1'b0;
    if (!is_flush) begin
      if (in_payload) begin
        has_res     = 1'b1;
        res_kind    = KIND_PAYLOAD;
        res_channel = frame_channel;
        res_len     = frame_length;
        res_byte    = in_byte;
        res_last    = (bytes_left == LEN_W'(1));
      end else if (hres.accept) begin
        has_res     = 1'b1;
        res_kind    = KIND_HEADER;
        res_channel = hres.channel;
        res_len     = hres.plen;
        res_last    = (hres.plen == '0);
      end else if (hres.discard) begin
        has_res  = 1'b1;
        res_byte = hres.lead_byte;
        res_over = hres.oversize;
      end
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_payload    <= 1'b0;
      frame_channel <= 8'd0;
      bytes_left    <= '0;
      frame_length  <= '0;
    end else if (adv) begin
      if (is_flush) begin
        in_payload    <= 1'b0;
        frame_channel <= 8'd0;
        bytes_left    <= '0;
        frame_length  <= '0;
      end else if (in_payload) begin
        bytes_left <= bytes_left - LEN_W'(1);
        if (bytes_left == LEN_W'(1)) in_payload <= 1'b0;
      end else if (hres.accept) begin
        in_payload    <= (hres.plen != '0);
        frame_channel <= hres.channel;
        bytes_left    <= hres.plen;
        frame_length  <= hres.plen;
      end
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= has_res;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (adv && has_res) begin
      out_kind     <= res_kind;
      out_channel  <= res_channel;
      out_len      <= res_len;
      out_byte     <= res_byte;
      out_last     <= res_last;
      out_over     <= res_over;
      out_frames   <= frames_next[OUT_CNT_W-1:0];
      out_discards <= discards_next[OUT_CNT_W-1:0];
      out_oversize <= oversize_next[OUT_CNT_W-1:0];
    end
  end

  assign m_tdata = {out_oversize, out_discards, out_frames, out_byte, out_len, out_channel};
  assign m_tuser = {out_over, out_kind};
  assign m_tlast = out_last;

  // a frame in progress always has bytes left to pass
  `MLFD_ASSERT_IMPL(a_payload_left, in_payload, bytes_left != '0, "payload with no bytes left")

  // a header marked last must carry a zero length
  `MLFD_ASSERT_IMPL(a_empty_header, m_tvalid && (out_kind == KIND_HEADER) && out_last, out_len == '0, "last header with nonzero length")

  // a payload byte always yields a result on the next cycle
  `MLFD_ASSERT_NEXT(a_payload_result, adv && !is_flush && in_payload, m_tvalid && (out_kind == KIND_PAYLOAD), "payload byte lost")

endmodule

### bench/marker_length_frame_deframer_tb.sv
`timescale 1ns / 100ps
// testbench of marker_length_frame_deframer: a directed table, then random streams under
// several register settings, every result checked against an in-bench deframer model
// depends on mlfd_pkg and the marker_length_frame_deframer rtl
module marker_length_frame_deframer_tb;
  import mlfd_pkg::*;

  localparam int HANG_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 4;
  localparam int BURST_ITEMS  = 200;
  localparam int NUM_PHASES   = 7;
  localparam int SHOW_FAILS   = 10;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  channel;
    logic [31:0] frame_len;
    logic [7:0]  out_byte;
    logic        last;
    logic        oversize;
    logic [31:0] frames_seen;
    logic [31:0] discards_seen;
    logic [31:0] oversize_seen;
  } deframe_res_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] data;
  } stream_item_t;

  // one directed row; pin set means the result fields below are fixed by hand
  typedef struct packed {
    stream_item_t item;
    logic         pin;
    kind_t        kind;
    logic [7:0]   channel;
    logic [31:0]  frame_len;
    logic [7:0]   out_byte;
    logic         last;
    logic         oversize;
  } table_row_t;

  logic          clk = 1'b0;
  logic          rst;
  logic          cfg_we;
  logic [1:0]    cfg_index;
  logic [31:0]   cfg_data;
  logic          s_tvalid;
  logic          s_tready;
  logic [7:0]    s_tdata;   // data_byte
  logic          s_tuser;   // cmd
  logic          m_tvalid;
  logic          m_tready = 1'b0;
  logic [143:0]  m_tdata;   // channel, frame_len, out_byte, frames_seen,
                            // discards_seen, oversize_seen
  logic [2:0]    m_tuser;   // kind[1:0], oversize
  logic          m_tlast;   // last

  // deframer model state and its copy of the registers
  logic [7:0]    hunt_win [8];
  int            hunt_fill;
  logic          in_frame;
  logic [7:0]    frame_ch;
  logic [31:0]   frame_left;
  logic [31:0]   frame_size;
  logic [31:0]   frame_cnt;
  logic [31:0]   discard_cnt;
  logic [31:0]   oversize_cnt;
  logic [31:0]   len_limit;
  logic [7:0]    ctrl_mk;
  logic [7:0]    video_mk;
  logic [7:0]    audio_mk;

  deframe_res_t  due_results [$];
  table_row_t    dir_rows [$];
  table_row_t    pin_row;
  int            fail_cnt = 0;
  int            quiet_cycles = 0;
  int            idle_pct = 0;
  int            hold_left = 0;

  marker_length_frame_deframer i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  // 12 ns clock
  always begin
    #6;
    clk = 1'b1;
    #6;
    clk = 1'b0;
  end

  function automatic logic [31:0] bump(input logic [31:0] c);
    return (c == '1) ? c : c + 32'd1;
  endfunction

  function automatic void clear_frame();
    for (int i = 0; i < 8; i++) hunt_win[i] = '0;
    hunt_fill  = 0;
    in_frame   = 1'b0;
    frame_ch   = '0;
    frame_left = '0;
    frame_size = '0;
  endfunction

  function automatic void drop_oldest();
    for (int i = 0; i < 7; i++) hunt_win[i] = hunt_win[i+1];
    hunt_win[7] = '0;
    hunt_fill--;
    discard_cnt = bump(discard_cnt);
  endfunction

  function automatic deframe_res_t make_res(input kind_t k, input logic [7:0] ch,
                                            input logic [31:0] len, input logic [7:0] ob,
                                            input logic last, input logic over);
    deframe_res_t r;
    r.kind          = k;
    r.channel       = ch;
    r.frame_len     = len;
    r.out_byte      = ob;
    r.last          = last;
    r.oversize      = over;
    r.frames_seen   = frame_cnt;
    r.discards_seen = discard_cnt;
    r.oversize_seen = oversize_cnt;
    return r;
  endfunction

  // one input transaction through the deframer model; got tells whether a result comes
  function automatic void deframe_byte(input cmd_t c, input logic [7:0] b,
                                       output bit got, output deframe_res_t r);
    logic [7:0]  m;
    logic [7:0]  first_byte;
    logic        first_over;
    logic        magic;
    logic [31:0] plen;
    bit          dropped;
    got        = 1'b0;
    r          = '0;
    dropped    = 1'b0;
    first_byte = '0;
    first_over = 1'b0;
    if (c == CMD_FLUSH) begin
      clear_frame();
      return;
    end
    // payload passes straight through
    if (in_frame && frame_left != 0) begin
      frame_left--;
      if (frame_left == 0) in_frame = 1'b0;
      r   = make_res(KIND_PAYLOAD, frame_ch, frame_size, b, frame_left == 0, 1'b0);
      got = 1'b1;
      return;
    end
    in_frame = 1'b0;
    if (hunt_fill >= 8) hunt_fill = 7;
    hunt_win[hunt_fill] = b;
    hunt_fill++;
    // retest the window until it holds a header, needs more bytes, or gets too short
    for (int guard = 0; guard < 9 && hunt_fill >= 4; guard++) begin
      m = hunt_win[0];
      magic = hunt_win[1] == m && hunt_win[2] == m && hunt_win[3] == m &&
              (m == ctrl_mk || m == video_mk || m == audio_mk);
      if (!magic) begin
        if (!dropped) begin
          first_byte = m;
          first_over = 1'b0;
          dropped    = 1'b1;
        end
        drop_oldest();
        continue;
      end
      if (hunt_fill < 8) break;
      plen = {hunt_win[7], hunt_win[6], hunt_win[5], hunt_win[4]};
      if (plen > len_limit) begin
        oversize_cnt = bump(oversize_cnt);
        if (!dropped) begin
          first_byte = m;
          first_over = 1'b1;
          dropped    = 1'b1;
        end
        drop_oldest();
        continue;
      end
      clear_frame();
      frame_cnt  = bump(frame_cnt);
      frame_ch   = m;
      frame_size = plen;
      frame_left = plen;
      in_frame   = plen != 0;
      r   = make_res(KIND_HEADER, m, plen, 8'h00, plen == 0, 1'b0);
      got = 1'b1;
      return;
    end
    if (dropped) begin
      r   = make_res(KIND_DISCARD, 8'h00, 32'h0, first_byte, 1'b0, first_over);
      got = 1'b1;
    end
  endfunction

  function automatic string show(input deframe_res_t r);
    return $sformatf("kind=%0d ch=%02h len=%08h byte=%02h last=%b over=%b cnt=%0d/%0d/%0d",
                     r.kind, r.channel, r.frame_len, r.out_byte, r.last, r.oversize,
                     r.frames_seen, r.discards_seen, r.oversize_seen);
  endfunction

  function automatic void note_fail(input string what, input deframe_res_t want,
                                    input deframe_res_t seen);
    fail_cnt++;
    if (fail_cnt <= SHOW_FAILS) begin
      $display("mismatch (%s) at %0t", what, $time);
      $display("  expected %s", show(want));
      $display("  actual   %s", show(seen));
    end
  endfunction

  // model update, result check and watchdog, all on the rising edge
  always @(posedge clk) begin
    bit           got;
    deframe_res_t want;
    deframe_res_t seen;
    if (rst) begin
      clear_frame();
      frame_cnt    = '0;
      discard_cnt  = '0;
      oversize_cnt = '0;
      len_limit    = 32'd1048576;
      ctrl_mk      = 8'h00;
      video_mk     = 8'h01;
      audio_mk     = 8'h02;
      quiet_cycles = 0;
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_MAX_LEN:  len_limit = cfg_data;
          REG_CTRL_MK:  ctrl_mk   = cfg_data[7:0];
          REG_VIDEO_MK: video_mk  = cfg_data[7:0];
          REG_AUDIO_MK: audio_mk  = cfg_data[7:0];
          default: ;
        endcase
      end
      // input transaction: predict, with hand-typed fields for pinned rows
      if (s_tvalid && s_tready) begin
        deframe_byte(cmd_t'(s_tuser), s_tdata, got, want);
        if (pin_row.pin) begin
          if (!got) begin
            note_fail("directed row gives no result", want, want);
          end else begin
            want.kind      = pin_row.kind;
            want.channel   = pin_row.channel;
            want.frame_len = pin_row.frame_len;
            want.out_byte  = pin_row.out_byte;
            want.last      = pin_row.last;
            want.oversize  = pin_row.oversize;
          end
        end
        if (got) due_results.push_back(want);
      end
      // result transaction: compare with the oldest prediction
      if (m_tvalid && m_tready) begin
        seen.kind          = kind_t'(m_tuser[1:0]);
        seen.oversize      = m_tuser[2];
        seen.last          = m_tlast;
        seen.channel       = m_tdata[7:0];
        seen.frame_len     = m_tdata[39:8];
        seen.out_byte      = m_tdata[47:40];
        seen.frames_seen   = m_tdata[79:48];
        seen.discards_seen = m_tdata[111:80];
        seen.oversize_seen = m_tdata[143:112];
        if (due_results.size() == 0) begin
          note_fail("result with nothing pending", '0, seen);
        end else begin
          want = due_results.pop_front();
          if (seen !== want) note_fail("field", want, seen);
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= HANG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // result side back-pressure in short random bursts
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      hold_left = $urandom_range(0, 3);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  function automatic stream_item_t item(input cmd_t c, input logic [7:0] d);
    stream_item_t it;
    it.cmd  = c;
    it.data = d;
    return it;
  endfunction

  function automatic table_row_t plain(input cmd_t c, input logic [7:0] d);
    table_row_t row;
    row      = '0;
    row.item = item(c, d);
    return row;
  endfunction

  function automatic table_row_t pinned(input logic [7:0] d, input kind_t k,
                                        input logic [7:0] ch, input logic [31:0] len,
                                        input logic [7:0] ob, input logic last,
                                        input logic over);
    table_row_t row;
    row.item      = item(CMD_BYTE, d);
    row.pin       = 1'b1;
    row.kind      = k;
    row.channel   = ch;
    row.frame_len = len;
    row.out_byte  = ob;
    row.last      = last;
    row.oversize  = over;
    return row;
  endfunction

  function automatic logic [7:0] pick_marker();
    case ($urandom_range(0, 3))
      0:       return ctrl_mk;
      1:       return video_mk;
      2:       return audio_mk;
      default: return 8'($urandom);
    endcase
  endfunction

  // one input transaction, after an optional random idle gap, held until s_tready takes it
  task automatic push_item(input stream_item_t it);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.cmd;
    s_tdata  <= it.data;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // mostly well-formed frames with random content, plus noise, broken headers, flushes
  task automatic random_traffic(input int n);
    stream_item_t chunk [$];
    int           sent;
    int           sel;
    int           len_cap;
    logic [7:0]   mk;
    logic [31:0]  len;
    bit           over;
    sent = 0;
    while (sent < n) begin
      chunk.delete();
      // a stray header with a huge length would swallow the rest of the run
      if (in_frame && frame_left > 16) chunk.push_back(item(CMD_FLUSH, 8'($urandom)));
      sel = $urandom_range(0, 99);
      if (sel < 62) begin
        mk   = pick_marker();
        over = len_limit != '1 && $urandom_range(0, 4) == 0;
        if (over) begin
          if ($urandom_range(0, 1) == 0) len = len_limit + 32'd1;
          else len = $urandom_range(len_limit + 32'd1, 32'hFFFF_FFFF);
        end else begin
          len_cap = (len_limit < 8) ? int'(len_limit) : 8;
          len     = $urandom_range(0, len_cap);
          if (len_limit <= 8 && $urandom_range(0, 2) == 0) len = len_limit;
        end
        repeat (4) chunk.push_back(item(CMD_BYTE, mk));
        for (int i = 0; i < 4; i++) chunk.push_back(item(CMD_BYTE, len[8*i +: 8]));
        if (!over) begin
          for (int i = 0; i < int'(len); i++) begin
            if ($urandom_range(0, 39) == 0) begin
              chunk.push_back(item(CMD_FLUSH, 8'($urandom)));
              break;
            end
            chunk.push_back(item(CMD_BYTE, 8'($urandom)));
          end
        end
      end else if (sel < 80) begin
        repeat ($urandom_range(1, 6)) chunk.push_back(item(CMD_BYTE, 8'($urandom)));
      end else if (sel < 93) begin
        // short marker run or truncated length
        mk = pick_marker();
        repeat ($urandom_range(1, 4)) chunk.push_back(item(CMD_BYTE, mk));
        repeat ($urandom_range(0, 3)) chunk.push_back(item(CMD_BYTE, 8'($urandom)));
      end else begin
        chunk.push_back(item(CMD_FLUSH, 8'($urandom)));
      end
      foreach (chunk[i]) push_item(chunk[i]);
      sent += chunk.size();
    end
  endtask

  // stop input and let every pending result and any result-less byte drain out
  task automatic settle();
    s_tvalid <= 1'b0;
    while (due_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_reg(input reg_idx_t idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
  endtask

  // register settings per phase: extremes first, then random ones, then back to reset values
  task automatic program_phase(input int p);
    logic [31:0] lim;
    logic [7:0]  c;
    logic [7:0]  v;
    logic [7:0]  a;
    c = 8'($urandom);
    v = 8'($urandom);
    a = 8'($urandom);
    case (p)
      1: begin
        lim = 32'd0;
        c   = 8'hFF;
        v   = 8'h00;
        a   = 8'h80;
      end
      2: begin
        lim = 32'hFFFF_FFFF;
        c   = 8'h55;
        v   = 8'h55;
        a   = 8'h55;
      end
      3: lim = $urandom_range(1, 8);
      4: begin
        lim = $urandom_range(9, 300);
        v   = c;
      end
      5: lim = $urandom;
      default: begin
        lim = 32'd1048576;
        c   = 8'h00;
        v   = 8'h01;
        a   = 8'h02;
      end
    endcase
    set_reg(REG_MAX_LEN, lim);
    set_reg(REG_CTRL_MK, {24'h0, c});
    set_reg(REG_VIDEO_MK, {24'h0, v});
    set_reg(REG_AUDIO_MK, {24'h0, a});
    cfg_we <= 1'b0;
  endtask

  initial begin
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_index <= REG_MAX_LEN;
    cfg_data  <= '0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= CMD_BYTE;
    pin_row    = '0;

    // zero-length frame on the control channel: the header itself is last
    repeat (7) dir_rows.push_back(plain(CMD_BYTE, 8'h00));
    dir_rows.push_back(pinned(8'h00, KIND_HEADER, 8'h00, 32'd0, 8'h00, 1'b1, 1'b0));
    // audio header with the largest length: oversize reject, the marker bytes dropped in the same step
    repeat (4) dir_rows.push_back(plain(CMD_BYTE, 8'h02));
    repeat (3) dir_rows.push_back(plain(CMD_BYTE, 8'hFF));
    dir_rows.push_back(pinned(8'hFF, KIND_DISCARD, 8'h00, 32'd0, 8'h02, 1'b0, 1'b1));
    // flush clears the leftover window, its data byte ignored
    dir_rows.push_back(plain(CMD_FLUSH, 8'hA5));
    // video frame with two payload bytes at the byte extremes
    repeat (4) dir_rows.push_back(plain(CMD_BYTE, 8'h01));
    dir_rows.push_back(plain(CMD_BYTE, 8'h02));
    repeat (2) dir_rows.push_back(plain(CMD_BYTE, 8'h00));
    dir_rows.push_back(pinned(8'h00, KIND_HEADER, 8'h01, 32'd2, 8'h00, 1'b0, 1'b0));
    dir_rows.push_back(pinned(8'hFF, KIND_PAYLOAD, 8'h01, 32'd2, 8'hFF, 1'b0, 1'b0));
    dir_rows.push_back(pinned(8'h00, KIND_PAYLOAD, 8'h01, 32'd2, 8'h00, 1'b1, 1'b0));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    idle_pct = 20;
    foreach (dir_rows[i]) begin
      pin_row = dir_rows[i];
      push_item(dir_rows[i].item);
    end
    pin_row = '0;

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p != 0) begin
        settle();
        program_phase(p);
      end
      if (p == NUM_PHASES - 1) begin
        idle_pct = 0;
      end else begin
        case ($urandom_range(0, 2))
          0:       idle_pct = 0;
          1:       idle_pct = 12;
          default: idle_pct = 30;
        endcase
      end
      random_traffic(BURST_ITEMS);
    end

    settle();
    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
